// ===== rtl/core/lkvc_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;
	localparam int ENTRIES     = 16;
	localparam int IDX_BITS    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_BITS    = $clog2(ENTRIES + 1);
	localparam int KEY_BITS    = 48;
	localparam int HANDLE_BITS = 32;
	localparam int LEN_BITS    = 24;
	localparam int CAP_BITS    = 5;
	localparam int QDEPTH      = 2;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef struct packed {
		op_t                    opcode;
		logic [KEY_BITS-1:0]    key;
		logic [HANDLE_BITS-1:0] handle;
		logic [LEN_BITS-1:0]    length;
	} req_t;

	typedef struct packed {
		logic                   hit;
		logic [HANDLE_BITS-1:0] handle;
		logic [LEN_BITS-1:0]    length;
	} rsp_t;
endpackage

// ===== rtl/core/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache.
//
// Requests enter on the in_valid/in_ready channel with opcode (get or put),
// key, value_handle and value_length. Each item gives exactly one result on
// the out_valid/out_ready channel: hit, found_handle and found_length.
// The front holds accepted items in a two-entry queue, so the input takes up
// to two items while the back is busy or the receiver stalls.
// The back takes one item at a time and scans the stored tags one entry per
// clock, then passes through the evict and update states before it shows
// the result, so the serial tag scan sets the throughput. A result stays on
// the output until it is taken; the back holds the next item until then,
// and the queue fills behind it.
// The capacity register is written by cfg_we with cfg_data; zero acts as
// one and values above the entry count saturate. It should only be written
// while the block is idle.
// Reset empties the cache, clears all ages and sets the capacity to 16.
module lru_key_value_cache (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lkvc_pkg::CAP_BITS-1:0]       cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                opcode,
	input  logic [lkvc_pkg::KEY_BITS-1:0]       key,
	input  logic [lkvc_pkg::HANDLE_BITS-1:0]    value_handle,
	input  logic [lkvc_pkg::LEN_BITS-1:0]       value_length,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit,
	output logic [lkvc_pkg::HANDLE_BITS-1:0]    found_handle,
	output logic [lkvc_pkg::LEN_BITS-1:0]       found_length
);
	logic [lkvc_pkg::CAP_BITS-1:0] capacity_q;
	logic           req_valid, req_take;
	lkvc_pkg::req_t req;
	lkvc_pkg::rsp_t rsp;

	// Capacity register, reset to the full entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) capacity_q <= lkvc_pkg::CAP_BITS'(16);
		else if (cfg_we) capacity_q <= cfg_data;
	end

	lkvc_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .opcode, .key, .value_handle,
		.value_length, .req_valid, .req_take, .req
	);

	lkvc_back u_back (
		.clk, .arst_n, .capacity(capacity_q), .req_valid, .req_take, .req,
		.out_valid, .out_ready, .rsp
	);

	assign hit          = rsp.hit;
	assign found_handle = rsp.handle;
	assign found_length = rsp.length;

	// A shown result holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rsp))
		else $error("result changed while stalled");

	// Handle and length are reported only on a hit.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> found_handle == '0 && found_length == '0)
		else $error("miss with nonzero data");
endmodule

// ===== rtl/core/lkvc_front.sv =====
// Front part: accepts requests and holds them in a short queue.
module lkvc_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         opcode,
	input  logic [lkvc_pkg::KEY_BITS-1:0]    key,
	input  logic [lkvc_pkg::HANDLE_BITS-1:0] value_handle,
	input  logic [lkvc_pkg::LEN_BITS-1:0]    value_length,
	output logic                         req_valid,
	input  logic                         req_take,
	output lkvc_pkg::req_t               req
);
	lkvc_pkg::req_t queue_q [lkvc_pkg::QDEPTH];
	logic [1:0] count_q;
	logic       wr_ptr_q, rd_ptr_q;
	logic       push, pop;

	assign in_ready  = (count_q != 2'(lkvc_pkg::QDEPTH));
	assign push      = in_valid && in_ready;
	assign req_valid = (count_q != 2'd0);
	assign pop       = req_valid && req_take;
	assign req       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{opcode: lkvc_pkg::op_t'(opcode), key: key,
				handle: value_handle, length: value_length};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== rtl/core/lkvc_back.sv =====
// Back part: scans the entries one per cycle, then updates ages and contents.
module lkvc_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [lkvc_pkg::CAP_BITS-1:0]     capacity,
	input  logic                              req_valid,
	output logic                              req_take,
	input  lkvc_pkg::req_t                    req,
	output logic                              out_valid,
	input  logic                              out_ready,
	output lkvc_pkg::rsp_t                    rsp
);
	localparam int IB = lkvc_pkg::IDX_BITS;
	localparam int CB = lkvc_pkg::CNT_BITS;
	localparam int N  = lkvc_pkg::ENTRIES;

	typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_EVICT, ST_FREE, ST_UPDATE, ST_OUT} state_t;

	logic [lkvc_pkg::KEY_BITS-1:0]    key_mem [N];
	logic [lkvc_pkg::HANDLE_BITS-1:0] hnd_mem [N];
	logic [lkvc_pkg::LEN_BITS-1:0]    len_mem [N];
	logic [N-1:0]  valid_q;
	logic [IB-1:0] age_q [N];
	logic [CB-1:0] used_q;

	state_t        state_q;
	lkvc_pkg::req_t req_q;
	logic [CB-1:0] scan_q;
	logic          hit_q, old_q, free_q;
	logic [IB-1:0] slot_q, old_idx_q, free_idx_q;
	logic [IB-1:0] ref_age_q;
	logic [IB-1:0] cur;
	logic [CB-1:0] cap_eff;

	assign cur      = scan_q[IB-1:0];
	assign req_take = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		if (capacity == '0) cap_eff = CB'(1);
		else if (32'(capacity) > N) cap_eff = CB'(N);
		else cap_eff = CB'(capacity);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE && req_q.opcode == lkvc_pkg::OP_PUT) begin
			key_mem[slot_q] <= req_q.key;
			hnd_mem[slot_q] <= req_q.handle;
			len_mem[slot_q] <= req_q.length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			used_q  <= '0;
			scan_q  <= '0;
			hit_q <= 1'b0; old_q <= 1'b0; free_q <= 1'b0;
			slot_q <= '0; old_idx_q <= '0; free_idx_q <= '0; ref_age_q <= '0;
			rsp <= '0;
			req_q <= '0;
			for (int i = 0; i < N; i++) age_q[i] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						req_q  <= req;
						scan_q <= '0;
						hit_q  <= 1'b0;
						old_q  <= 1'b0;
						free_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// One entry per cycle: key match, oldest valid, first free.
					if (valid_q[cur]) begin
						if (!hit_q && key_mem[cur] == req_q.key) begin
							hit_q <= 1'b1;
							slot_q <= cur;
							ref_age_q <= age_q[cur];
						end
						if (!old_q || age_q[cur] > age_q[old_idx_q]) begin
							old_q <= 1'b1;
							old_idx_q <= cur;
						end
					end else if (!free_q) begin
						free_q <= 1'b1;
						free_idx_q <= cur;
					end
					if (scan_q == CB'(N - 1)) state_q <= ST_EVICT;
					scan_q <= scan_q + CB'(1);
				end
				ST_EVICT: begin
					state_q <= ST_UPDATE;
					if (!hit_q && req_q.opcode == lkvc_pkg::OP_PUT) begin
						if ((used_q >= cap_eff || !free_q) && old_q) begin
							// The lower of the evicted slot and the first free slot is the one reused.
							valid_q[old_idx_q] <= 1'b0;
							age_q[old_idx_q] <= '0;
							used_q <= used_q - CB'(1);
							if (!free_q || old_idx_q < free_idx_q) slot_q <= old_idx_q;
							else slot_q <= free_idx_q;
						end else begin
							slot_q <= free_idx_q;
						end
					end
				end
				ST_UPDATE: begin
					rsp.hit <= hit_q;
					rsp.handle <= '0;
					rsp.length <= '0;
					if (hit_q) begin
						for (int i = 0; i < N; i++)
							if (valid_q[i] && age_q[i] < ref_age_q) age_q[i] <= age_q[i] + IB'(1);
						age_q[slot_q] <= '0;
						if (req_q.opcode == lkvc_pkg::OP_GET) begin
							rsp.handle <= hnd_mem[slot_q];
							rsp.length <= len_mem[slot_q];
						end
					end else if (req_q.opcode == lkvc_pkg::OP_PUT) begin
						for (int i = 0; i < N; i++)
							if (valid_q[i]) age_q[i] <= age_q[i] + IB'(1);
						age_q[slot_q] <= '0;
						valid_q[slot_q] <= 1'b1;
						used_q <= used_q + CB'(1);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== verif/tb_lru_key_value_cache.sv =====
// Self-checking testbench for the LRU key-value cache: directed and random traffic, checked on every result.
`timescale 1ns / 100ps

module tb_lru_key_value_cache;
	// Clock, reset and the ports of the block.
	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [lkvc_pkg::CAP_BITS-1:0]    cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	logic                             opcode = 1'b0;
	logic [lkvc_pkg::KEY_BITS-1:0]    key = '0;
	logic [lkvc_pkg::HANDLE_BITS-1:0] value_handle = '0;
	logic [lkvc_pkg::LEN_BITS-1:0]    value_length = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic                             hit;
	logic [lkvc_pkg::HANDLE_BITS-1:0] found_handle;
	logic [lkvc_pkg::LEN_BITS-1:0]    found_length;

	// Cycles with no accepted item on either channel before the run is given up.
	// The slowest item waits a long receiver stall on top of its pass through
	// the block, with a two-deep queue in front.
	localparam int WATCHDOG_LIMIT = 2000;
	// Cycles to let pass after the last result before a register write or the end.
	localparam int SETTLE_CYCLES = 30;

	lru_key_value_cache i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.key          (key),
		.value_handle (value_handle),
		.value_length (value_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.found_handle (found_handle),
		.found_length (found_length)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Requests waiting to be driven and the responses the cache owes us.
	lkvc_pkg::req_t pending_reqs[$];
	lkvc_pkg::rsp_t owed_rsps[$];
	int   fail_count = 0;
	bit   no_idle = 1'b0;

	// Shadow copy of the cache contents, updated as each request is accepted.
	logic [lkvc_pkg::CAP_BITS-1:0]    shadow_cap = 5'd16;
	bit                               shadow_valid[lkvc_pkg::ENTRIES];
	logic [lkvc_pkg::KEY_BITS-1:0]    shadow_key[lkvc_pkg::ENTRIES];
	logic [lkvc_pkg::HANDLE_BITS-1:0] shadow_handle[lkvc_pkg::ENTRIES];
	logic [lkvc_pkg::LEN_BITS-1:0]    shadow_length[lkvc_pkg::ENTRIES];
	int                               shadow_age[lkvc_pkg::ENTRIES];
	int                               shadow_used = 0;

	// Keys are mostly drawn from a small pool so that hits and updates are common.
	logic [lkvc_pkg::KEY_BITS-1:0] key_pool[32];
	int                            pool_size = 8;

	// Gap length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Applies one request to the shadow cache and returns the response it must give.
	function automatic lkvc_pkg::rsp_t lookup_and_update(lkvc_pkg::req_t r);
		lkvc_pkg::rsp_t rsp;
		int   slot;
		int   old_age;
		int   oldest;
		int   free_slot;
		int   eff_cap;
		rsp = '0;
		slot = -1;
		for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
			if (slot < 0 && shadow_valid[i] && shadow_key[i] == r.key)
				slot = i;
		rsp.hit = (slot >= 0);
		if (slot >= 0) begin
			// A hit, get or put, moves the entry to the front; younger ones age by one.
			old_age = shadow_age[slot];
			for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
				if (shadow_valid[i] && shadow_age[i] < old_age)
					shadow_age[i]++;
			shadow_age[slot] = 0;
			if (r.opcode == lkvc_pkg::OP_GET) begin
				rsp.handle = shadow_handle[slot];
				rsp.length = shadow_length[slot];
			end else begin
				shadow_handle[slot] = r.handle;
				shadow_length[slot] = r.length;
			end
			return rsp;
		end
		if (r.opcode == lkvc_pkg::OP_GET)
			return rsp;
		// Zero capacity acts as one, anything above the entry count saturates.
		if (shadow_cap == 0)
			eff_cap = 1;
		else if (shadow_cap > lkvc_pkg::ENTRIES)
			eff_cap = lkvc_pkg::ENTRIES;
		else
			eff_cap = shadow_cap;
		if (shadow_used >= eff_cap) begin
			// Only one entry goes even when the capacity was lowered below the fill level.
			oldest = -1;
			for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
				if (shadow_valid[i] && (oldest < 0 || shadow_age[i] > shadow_age[oldest]))
					oldest = i;
			if (oldest >= 0) begin
				shadow_valid[oldest] = 1'b0;
				shadow_age[oldest] = 0;
				shadow_used--;
			end
		end
		free_slot = -1;
		for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
			if (free_slot < 0 && !shadow_valid[i])
				free_slot = i;
		for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
			if (shadow_valid[i])
				shadow_age[i]++;
		shadow_valid[free_slot] = 1'b1;
		shadow_key[free_slot] = r.key;
		shadow_handle[free_slot] = r.handle;
		shadow_length[free_slot] = r.length;
		shadow_age[free_slot] = 0;
		shadow_used++;
		return rsp;
	endfunction

	// Request driver. An accepted item is predicted on the same edge; a new item
	// follows after a random gap, and a valid item is held until it is taken.
	int send_gap = 0;
	always @(posedge clk) begin
		if (in_valid && in_ready)
			owed_rsps.push_back(lookup_and_update({lkvc_pkg::op_t'(opcode), key,
				value_handle, value_length}));
		if (!in_valid || in_ready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 0 && arst_n) begin
				lkvc_pkg::req_t nxt;
				nxt = pending_reqs.pop_front();
				opcode <= nxt.opcode;
				key <= nxt.key;
				value_handle <= nxt.handle;
				value_length <= nxt.length;
				in_valid <= 1'b1;
				send_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Response monitor with a randomly stalling receiver. Every field of an
	// accepted response is compared against the oldest owed response.
	int stall_left = 0;
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (owed_rsps.size() == 0) begin
				$error("response with none owed: hit=%0d handle=%h length=%h",
					hit, found_handle, found_length);
				fail_count++;
			end else begin
				lkvc_pkg::rsp_t want;
				want = owed_rsps.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					fail_count++;
				end
				if (found_handle !== want.handle) begin
					$error("found_handle: expected %h, got %h", want.handle, found_handle);
					fail_count++;
				end
				if (found_length !== want.length) begin
					$error("found_length: expected %h, got %h", want.length, found_length);
					fail_count++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!out_valid || out_ready)
				stall_left <= pick_gap();
		end
	end

	// Watchdog: a run that stops accepting anything for too long has hung.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Waits until every queued item is taken and every owed response has come,
	// then lets the block settle so a register write finds it idle.
	task automatic drain();
		@(negedge clk);
		while (pending_reqs.size() > 0 || in_valid || owed_rsps.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_capacity(logic [lkvc_pkg::CAP_BITS-1:0] cap);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= cap;
		shadow_cap = cap;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_req(lkvc_pkg::op_t op, logic [lkvc_pkg::KEY_BITS-1:0] k,
			logic [lkvc_pkg::HANDLE_BITS-1:0] h, logic [lkvc_pkg::LEN_BITS-1:0] len);
		lkvc_pkg::req_t r;
		r.opcode = op;
		r.key = k;
		r.handle = h;
		r.length = len;
		pending_reqs.push_back(r);
	endtask

	// Random request: pool keys most of the time, a fresh random key now and
	// then, and full-width random handles and lengths with the extremes mixed in.
	task automatic queue_random_req();
		logic [lkvc_pkg::KEY_BITS-1:0]    k;
		logic [lkvc_pkg::HANDLE_BITS-1:0] h;
		logic [lkvc_pkg::LEN_BITS-1:0]    len;
		if ($urandom_range(0, 9) == 0)
			k = lkvc_pkg::KEY_BITS'({$urandom, $urandom});
		else
			k = key_pool[$urandom_range(0, pool_size - 1)];
		case ($urandom_range(0, 9))
			0: h = '0;
			1: h = '1;
			default: h = $urandom;
		endcase
		case ($urandom_range(0, 9))
			0: len = '0;
			1: len = '1;
			default: len = lkvc_pkg::LEN_BITS'($urandom);
		endcase
		queue_req(lkvc_pkg::op_t'($urandom_range(0, 1)), k, h, len);
	endtask

	initial begin
		logic [lkvc_pkg::CAP_BITS-1:0] caps[12];
		for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_age[i] = 0;
		end
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < 32; i++)
			key_pool[i] = lkvc_pkg::KEY_BITS'({$urandom, $urandom});

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset capacity of 16: extreme keys and values,
		// misses, hits, an update, and zero fields on a put.
		queue_req(lkvc_pkg::OP_GET, '0, '1, '1);
		queue_req(lkvc_pkg::OP_PUT, '0, '1, '1);
		queue_req(lkvc_pkg::OP_PUT, '1, '0, '0);
		queue_req(lkvc_pkg::OP_GET, '0, '0, '0);
		queue_req(lkvc_pkg::OP_GET, '1, '1, '1);
		queue_req(lkvc_pkg::OP_PUT, '0, 32'h5a5a_a5a5, 24'h00_0001);
		queue_req(lkvc_pkg::OP_GET, '0, '0, '0);
		queue_req(lkvc_pkg::OP_GET, 48'h1234_5678_9abc, '0, '0);
		drain();

		// Capacity zero behaves as one: each new key pushes the oldest entry out.
		write_capacity(5'd0);
		queue_req(lkvc_pkg::OP_PUT, key_pool[2], 32'h1111_1111, 24'h11_1111);
		queue_req(lkvc_pkg::OP_PUT, key_pool[3], 32'h2222_2222, 24'h22_2222);
		queue_req(lkvc_pkg::OP_GET, key_pool[2], '0, '0);
		queue_req(lkvc_pkg::OP_GET, key_pool[3], '0, '0);
		drain();

		// Above the entry count the capacity saturates; fill all sixteen entries.
		write_capacity(5'd31);
		for (int i = 0; i < 17; i++)
			queue_req(lkvc_pkg::OP_PUT, key_pool[i + 4], $urandom,
				lkvc_pkg::LEN_BITS'($urandom));
		drain();

		// Capacity dropped below the fill level: each new key evicts just one entry.
		write_capacity(5'd2);
		queue_req(lkvc_pkg::OP_PUT, key_pool[30], '1, '1);
		queue_req(lkvc_pkg::OP_GET, key_pool[20], '0, '0);
		queue_req(lkvc_pkg::OP_GET, key_pool[30], '0, '0);
		drain();

		// Random phases across a range of capacities, extremes included.
		// Each phase ends with the sender held back until all responses are in.
		caps = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd4, 5'd8, 5'd15, 5'd17, 5'd2, 5'd16, 5'd3, 5'd10};
		for (int p = 0; p < 12; p++) begin
			write_capacity((p % 3 == 2) ? 5'($urandom_range(0, 31)) : caps[p]);
			pool_size = $urandom_range(3, 32);
			no_idle = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < 150; n++)
				queue_random_req();
			drain();
		end

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_front.sv
rtl/core/lkvc_back.sv
rtl/core/lru_key_value_cache.sv
verif/tb_lru_key_value_cache.sv
